// File: hw/rtl/vks_pkg.sv
// Shared types and constants for the velocity key scanner.
package vks_pkg;

  localparam logic ACT_TICK = 1'b0;
  localparam logic ACT_SCAN = 1'b1;

  localparam logic EV_ON  = 1'b0;
  localparam logic EV_OFF = 1'b1;

  localparam logic [1:0] REG_START_NOTE = 2'd0;
  localparam logic [1:0] REG_WIDE_VEL   = 2'd1;
  localparam logic [1:0] REG_CHANNEL    = 2'd2;

  localparam logic [6:0] START_NOTE_RESET = 7'd48;

  localparam logic [15:0] VEL_MIN     = 16'd100;
  localparam logic [15:0] VEL_MAX     = 16'd10100;
  localparam logic [13:0] VEL_SPAN    = 14'd10000;
  localparam logic [13:0] RECIP_78    = 14'd13444;
  localparam int          RECIP_SHIFT = 20;
  localparam logic [7:0]  VEL7_TOP    = 8'h7F;
  localparam logic [15:0] VEL16_TOP   = 16'd65535;
  localparam logic [15:0] WIDE_SCALE  = 16'd6;

  localparam int QUEUE_AW = 2;

  typedef struct packed {
    logic       action;
    logic [1:0] column;
    logic [7:0] detect_bits;
    logic [7:0] press_bits;
  } in_beat_t;

  typedef struct packed {
    logic        event_kind;
    logic [7:0]  note_number;
    logic [15:0] note_velocity;
    logic [3:0]  event_channel;
    logic        last_event;
  } out_beat_t;

  typedef struct packed {
    logic [1:0]  column;
    logic [7:0]  detect_bits;
    logic [7:0]  press_bits;
    logic [15:0] tick;
  } scan_t;

  typedef struct packed {
    logic [6:0] start_note;
    logic       wide_velocity_mode;
    logic [3:0] channel;
  } cfg_t;

  typedef enum logic [1:0] {
    PH_RELEASED = 2'd0,
    PH_DETECT   = 2'd1,
    PH_PRESSED  = 2'd2
  } phase_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_WALK,
    S_READ,
    S_MAP,
    S_EMIT
  } back_state_t;

endpackage

// File: hw/rtl/vks_front.sv
// Front end: takes input beats, keeps the tick counter, queues scans with a time stamp.
module vks_front import vks_pkg::*; #(
  parameter int COLUMNS = 4
) (
  input  logic     clk,
  input  logic     rst,
  input  logic     in_valid,
  output logic     in_ready,
  input  in_beat_t in_data,
  output logic     q_valid,
  input  logic     q_ready,
  output scan_t    q_data
);

  logic [15:0] tick_count;
  logic        accept;

  assign in_ready = q_ready;
  assign accept   = in_valid && in_ready;

  assign q_valid = accept && (in_data.action == ACT_SCAN) &&
                   (4'(in_data.column) < 4'(COLUMNS));
  assign q_data  = '{column:      in_data.column,
                     detect_bits: in_data.detect_bits,
                     press_bits:  in_data.press_bits,
                     tick:        tick_count};

  always_ff @(posedge clk) begin
    if (rst) begin
      tick_count <= '0;
    end else if (accept && (in_data.action == ACT_TICK)) begin
      tick_count <= tick_count + 16'd1;
    end
  end

endmodule

// File: hw/rtl/vks_fifo.sv
// Short scan queue between front and back end.
module vks_fifo import vks_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  logic  push,
  output logic  not_full,
  input  scan_t push_data,
  output logic  not_empty,
  input  logic  pop,
  output scan_t pop_data
);

  localparam int DEPTH = 1 << QUEUE_AW;

  scan_t               entries [DEPTH];
  logic [QUEUE_AW-1:0] wr_ptr;
  logic [QUEUE_AW-1:0] rd_ptr;
  logic [QUEUE_AW:0]   count;
  logic                do_push;
  logic                do_pop;

  assign not_full  = (count != (QUEUE_AW+1)'(DEPTH));
  assign not_empty = (count != '0);
  assign do_push   = push && not_full;
  assign do_pop    = pop && not_empty;
  assign pop_data  = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

// File: hw/rtl/vks_back.sv
// Back end: key phase update, detect time memory, velocity map and event output register.
module vks_back import vks_pkg::*; #(
  parameter int GROUPS  = 8,
  parameter int COLUMNS = 4
) (
  input  logic      clk,
  input  logic      rst,
  input  logic      q_valid,
  output logic      q_ready,
  input  scan_t     q_data,
  input  cfg_t      cfg,
  output logic      out_valid,
  input  logic      out_ready,
  output out_beat_t out_data
);

  localparam int GW    = (GROUPS > 1) ? $clog2(GROUPS) : 1;
  localparam int CW    = (COLUMNS > 1) ? $clog2(COLUMNS) : 1;
  localparam int DEPTH = 1 << (GW + CW);

  back_state_t state, state_next;

  phase_t phase [GROUPS][COLUMNS];
  phase_t cur_ph [GROUPS];
  phase_t ph_next [GROUPS];
  logic [GROUPS-1:0] emit_n, off_n, set_n;
  logic [GROUPS+7:0] det_ext, prs_ext;
  logic [CW-1:0]     q_col;

  logic [GROUPS-1:0] emit, off, setm, above;
  logic [GW-1:0]     grp;
  logic [CW-1:0]     col;
  logic [15:0]       tick;
  logic [13:0]       vclamp;
  logic [15:0]       vel;

  logic [15:0] dt_mem [DEPTH];
  logic [15:0] rdata;
  logic [GW+CW-1:0] mem_addr;

  logic        pop, mem_we, mem_re, load_out, advance, out_free, last_grp;
  logic [15:0] elapsed;
  logic [27:0] recip_prod;
  logic [7:0]  quot;
  logic [6:0]  sat7;
  logic [15:0] wide_vel;

  assign q_col    = CW'(q_data.column);
  assign out_free = !out_valid || out_ready;
  assign last_grp = (grp == GW'(GROUPS - 1));
  assign mem_addr = {grp, col};

  always_comb begin
    det_ext = {{GROUPS{1'b0}}, q_data.detect_bits};
    prs_ext = {{GROUPS{1'b0}}, q_data.press_bits};
    for (int g = 0; g < GROUPS; g++) begin
      cur_ph[g]  = phase[g][q_col];
      ph_next[g] = cur_ph[g];
      emit_n[g]  = 1'b0;
      off_n[g]   = 1'b0;
      set_n[g]   = 1'b0;
      if (det_ext[g]) begin
        if (cur_ph[g] == PH_RELEASED) begin
          ph_next[g] = PH_DETECT;
          set_n[g]   = 1'b1;
        end else if ((cur_ph[g] == PH_DETECT) && prs_ext[g]) begin
          ph_next[g] = PH_PRESSED;
          emit_n[g]  = 1'b1;
        end
      end else begin
        if (cur_ph[g] == PH_PRESSED) begin
          emit_n[g] = 1'b1;
          off_n[g]  = 1'b1;
        end
        ph_next[g] = PH_RELEASED;
      end
    end
  end

  always_comb begin
    for (int i = 0; i < GROUPS; i++) begin
      above[i] = emit[i] && (i > int'(grp));
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (q_valid) state_next = S_WALK;
      end
      S_WALK: begin
        if (emit[grp]) begin
          state_next = off[grp] ? S_EMIT : S_READ;
        end else if (last_grp) begin
          state_next = S_IDLE;
        end
      end
      S_READ: state_next = S_MAP;
      S_MAP:  state_next = S_EMIT;
      S_EMIT: begin
        if (out_free) state_next = last_grp ? S_IDLE : S_WALK;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    q_ready  = (state == S_IDLE);
    mem_we   = (state == S_WALK) && setm[grp];
    mem_re   = (state == S_WALK) && emit[grp] && !off[grp];
    load_out = (state == S_EMIT) && out_free;
    advance  = ((state == S_WALK) && !emit[grp]) || load_out;
  end

  assign pop = q_valid && q_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int g = 0; g < GROUPS; g++) begin
        for (int c = 0; c < COLUMNS; c++) begin
          phase[g][c] <= PH_RELEASED;
        end
      end
    end else if (pop) begin
      for (int g = 0; g < GROUPS; g++) begin
        phase[g][q_col] <= ph_next[g];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      dt_mem[mem_addr] <= tick;
    end
    if (mem_re) begin
      rdata <= dt_mem[mem_addr];
    end
  end

  assign elapsed    = tick - rdata;
  assign recip_prod = 28'(vclamp) * 28'(RECIP_78);
  assign quot       = recip_prod[RECIP_SHIFT +: 8];
  assign sat7       = (quot > VEL7_TOP) ? 7'd0 : 7'(VEL7_TOP - quot);
  assign wide_vel   = VEL16_TOP - 16'(vclamp) * WIDE_SCALE;

  always_ff @(posedge clk) begin
    if (pop) begin
      col  <= q_col;
      tick <= q_data.tick;
      emit <= emit_n;
      off  <= off_n;
      setm <= set_n;
      grp  <= '0;
    end else if (advance) begin
      grp <= grp + 1'b1;
    end
    if (state == S_READ) begin
      if (elapsed > VEL_MAX) begin
        vclamp <= VEL_SPAN;
      end else if (elapsed < VEL_MIN) begin
        vclamp <= '0;
      end else begin
        vclamp <= 14'(elapsed - VEL_MIN);
      end
    end
    if (state == S_MAP) begin
      vel <= cfg.wide_velocity_mode ? wide_vel : {9'd0, sat7};
    end else if ((state == S_WALK) && off[grp]) begin
      vel <= '0;
    end
    if (load_out) begin
      out_data.event_kind    <= off[grp] ? EV_OFF : EV_ON;
      out_data.note_number   <= 8'(int'(grp) * COLUMNS + int'(col) + int'(cfg.start_note));
      out_data.note_velocity <= vel;
      out_data.event_channel <= cfg.channel;
      out_data.last_event    <= ~|above;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load_out) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

endmodule

// File: hw/rtl/velocity_key_scanner_top.sv
// Top level of the velocity key scanner: front end, scan queue, back end, APB registers.
//
// channel  signals                          beat
// in       in_valid / in_ready / in_data    tick or one column scan (in_beat_t)
// out      out_valid / out_ready / out_data one note event (out_beat_t)
// apb      psel penable pwrite paddr ...    register write / read
//
// Ticks are taken one per cycle while the queue is not full. A scan occupies the back end
// while it walks the groups in turn, with S_READ, S_MAP and S_EMIT per note-on, S_EMIT
// per note-off and any wait on out_ready; the single detect time memory port sets this.
// The queue holds 4 scans; once it is full in_ready drops for ticks and scans alike.
// rst is synchronous; the detect time memory needs no clearing pass after reset.
module velocity_key_scanner_top import vks_pkg::*; #(
  parameter int GROUPS  = 8,
  parameter int COLUMNS = 4
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  in_beat_t    in_data,
  output logic        out_valid,
  input  logic        out_ready,
  output out_beat_t   out_data,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  cfg_t  cfg;
  logic  push, not_full, not_empty, pop;
  scan_t push_data, pop_data;
  logic  cfg_write;

  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.start_note         <= START_NOTE_RESET;
      cfg.wide_velocity_mode <= 1'b0;
      cfg.channel            <= '0;
    end else if (cfg_write) begin
      unique case (paddr[3:2])
        REG_START_NOTE: cfg.start_note         <= pwdata[6:0];
        REG_WIDE_VEL:   cfg.wide_velocity_mode <= pwdata[0];
        REG_CHANNEL:    cfg.channel            <= pwdata[3:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[3:2])
      REG_START_NOTE: prdata = {25'd0, cfg.start_note};
      REG_WIDE_VEL:   prdata = {31'd0, cfg.wide_velocity_mode};
      REG_CHANNEL:    prdata = {28'd0, cfg.channel};
      default:        prdata = '0;
    endcase
  end

  vks_front #(.COLUMNS(COLUMNS)) u_front (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .q_valid  (push),
    .q_ready  (not_full),
    .q_data   (push_data)
  );

  vks_fifo u_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .not_full  (not_full),
    .push_data (push_data),
    .not_empty (not_empty),
    .pop       (pop),
    .pop_data  (pop_data)
  );

  vks_back #(.GROUPS(GROUPS), .COLUMNS(COLUMNS)) u_back (
    .clk       (clk),
    .rst       (rst),
    .q_valid   (not_empty),
    .q_ready   (pop),
    .q_data    (pop_data),
    .cfg       (cfg),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  a_off_zero_vel: assert property (@(posedge clk) disable iff (rst)
    out_valid && (out_data.event_kind == EV_OFF) |-> (out_data.note_velocity == 16'd0))
    else $error("note-off beat carries a velocity");

  a_narrow_vel: assert property (@(posedge clk) disable iff (rst)
    out_valid && (out_data.event_kind == EV_ON) && !cfg.wide_velocity_mode
      |-> (out_data.note_velocity <= 16'd127))
    else $error("7-bit velocity out of range");

  a_reset_quiet: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("event beat right after reset");

  a_channel: assert property (@(posedge clk) disable iff (rst)
    out_valid && !$past(out_valid) |-> (out_data.event_channel == cfg.channel))
    else $error("event channel differs from register");

endmodule

// File: bench/tb_velocity_key_scanner_top.sv
// Testbench for velocity_key_scanner_top: directed and random key scans checked by a predictor.
`timescale 1ns / 100ps

import vks_pkg::*;

class key_scan_board;
  localparam int GROUP_COUNT  = 8;
  localparam int COLUMN_COUNT = 4;
  localparam int KEY_COUNT    = GROUP_COUNT * COLUMN_COUNT;
  localparam int VEL_STEP     = 78;

  logic [6:0]  start_note;
  logic        wide_mode;
  logic [3:0]  chan;
  logic [15:0] tick_count;
  phase_t      phase [KEY_COUNT];
  logic [15:0] armed_tick [KEY_COUNT];
  out_beat_t   pending [$];
  int          errors;

  function new();
    start_note = START_NOTE_RESET;
    wide_mode  = 1'b0;
    chan       = '0;
    tick_count = '0;
    errors     = 0;
    foreach (phase[k]) begin
      phase[k]      = PH_RELEASED;
      armed_tick[k] = '0;
    end
  endfunction

  function void set_reg(logic [1:0] idx, logic [31:0] val);
    case (idx)
      REG_START_NOTE: start_note = val[6:0];
      REG_WIDE_VEL:   wide_mode  = val[0];
      REG_CHANNEL:    chan       = val[3:0];
      default: ;
    endcase
  endfunction

  function logic [15:0] velocity_for(logic [15:0] elapsed);
    int unsigned v;
    int unsigned q;
    v = elapsed;
    if (v > VEL_MAX) v = VEL_MAX;
    if (v < VEL_MIN) v = VEL_MIN;
    v = v - VEL_MIN;
    if (wide_mode) return 16'(VEL16_TOP - WIDE_SCALE * v);
    q = v / VEL_STEP;
    return (q > VEL7_TOP) ? 16'd0 : 16'(VEL7_TOP - q);
  endfunction

  function void take_scan(in_beat_t b);
    int        k;
    logic      emit;
    logic      have_held;
    out_beat_t ev;
    out_beat_t held;
    if (b.action == ACT_TICK) begin
      tick_count = tick_count + 16'd1;
      return;
    end
    have_held = 1'b0;
    held = '0;
    for (int g = 0; g < GROUP_COUNT; g++) begin
      k = int'(b.column) + g * COLUMN_COUNT;
      emit = 1'b0;
      ev = '0;
      if (b.detect_bits[g]) begin
        if (phase[k] == PH_RELEASED) begin
          phase[k] = PH_DETECT;
          armed_tick[k] = tick_count;
        end else if (phase[k] == PH_DETECT && b.press_bits[g]) begin
          phase[k] = PH_PRESSED;
          ev.event_kind = EV_ON;
          ev.note_velocity = velocity_for(16'(tick_count - armed_tick[k]));
          emit = 1'b1;
        end
      end else begin
        if (phase[k] == PH_PRESSED) begin
          ev.event_kind = EV_OFF;
          ev.note_velocity = '0;
          emit = 1'b1;
        end
        phase[k] = PH_RELEASED;
      end
      if (emit) begin
        ev.note_number = 8'(k + int'(start_note));
        ev.event_channel = chan;
        ev.last_event = 1'b0;
        if (have_held) pending.push_back(held);
        held = ev;
        have_held = 1'b1;
      end
    end
    if (have_held) begin
      held.last_event = 1'b1;
      pending.push_back(held);
    end
  endfunction

  task flag(string what);
    errors++;
    $display("%0t mismatch: %s", $time, what);
  endtask

  task match_event(out_beat_t got);
    out_beat_t want;
    if (pending.size() == 0) begin
      flag($sformatf("note event with none pending: %p", got));
      return;
    end
    want = pending.pop_front();
    if (got.event_kind !== want.event_kind)
      flag($sformatf("event_kind %0d, want %0d", got.event_kind, want.event_kind));
    if (got.note_number !== want.note_number)
      flag($sformatf("note_number %0d, want %0d", got.note_number, want.note_number));
    if (got.note_velocity !== want.note_velocity)
      flag($sformatf("note_velocity %0d, want %0d", got.note_velocity, want.note_velocity));
    if (got.event_channel !== want.event_channel)
      flag($sformatf("event_channel %0d, want %0d", got.event_channel, want.event_channel));
    if (got.last_event !== want.last_event)
      flag($sformatf("last_event %0d, want %0d", got.last_event, want.last_event));
  endtask
endclass

module tb_velocity_key_scanner_top;
  localparam int CYCLE_LIMIT  = 1_000_000;
  localparam int QUIET_CYCLES = 200;
  localparam int HOLD_CYCLES  = 400;
  localparam int GROUP_COUNT  = 8;
  localparam int COLUMN_COUNT = 4;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_ready;
  in_beat_t    in_data = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  out_beat_t   out_data;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [3:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  int   tx_idle_pct = 14;
  int   rx_idle_pct = 46;
  logic hold_req = 1'b0;
  logic hold_taken = 1'b0;
  int   hold_left = 0;
  int   cycles = 0;

  key_scan_board board;

  velocity_key_scanner_top u_top (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .in_data(in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data(out_data),
    .psel(psel),
    .penable(penable),
    .pwrite(pwrite),
    .paddr(paddr),
    .pwdata(pwdata),
    .prdata(prdata),
    .pready(pready)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("tb_velocity_key_scanner_top: errors");
      $finish;
    end
  end

  // receiver: random stalls, plus one long hold-off on request
  always @(posedge clk) begin
    if (hold_req && !hold_taken) begin
      hold_taken <= 1'b1;
      hold_left <= HOLD_CYCLES;
      out_ready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= rx_idle_pct);
    end
  end

  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) board.match_event(out_data);
  end

  task automatic send_beat(in_beat_t b);
    if ($urandom_range(99) < tx_idle_pct) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    in_data <= b;
    in_valid <= 1'b1;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    board.take_scan(b);
  endtask

  task automatic send_scan(logic [1:0] col, logic [7:0] det, logic [7:0] prs);
    in_beat_t b;
    b.action = ACT_SCAN;
    b.column = col;
    b.detect_bits = det;
    b.press_bits = prs;
    send_beat(b);
  endtask

  task automatic tick_burst(int n);
    in_beat_t b;
    repeat (n) begin
      b = in_beat_t'($urandom);
      b.action = ACT_TICK;
      send_beat(b);
    end
  endtask

  function automatic in_beat_t make_scan();
    in_beat_t b;
    int       k;
    int       r;
    b.action = ACT_SCAN;
    b.column = 2'($urandom_range(3));
    b.detect_bits = '0;
    b.press_bits = '0;
    if ($urandom_range(99) < 12) begin
      b.detect_bits = 8'($urandom);
      b.press_bits = 8'($urandom);
      return b;
    end
    // follow each key's phase so most keys walk detect -> press -> release
    for (int g = 0; g < GROUP_COUNT; g++) begin
      k = int'(b.column) + g * COLUMN_COUNT;
      r = $urandom_range(99);
      case (board.phase[k])
        PH_RELEASED: begin
          b.detect_bits[g] = (r < 55);
          b.press_bits[g] = ($urandom_range(99) < 25);
        end
        PH_DETECT: begin
          b.detect_bits[g] = (r >= 15);
          b.press_bits[g] = ($urandom_range(99) < 55);
        end
        default: begin
          b.detect_bits[g] = (r >= 35);
          b.press_bits[g] = 1'($urandom_range(1));
        end
      endcase
    end
    return b;
  endfunction

  task automatic apb_write(logic [1:0] idx, logic [31:0] val);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= val;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    board.set_reg(idx, val);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(posedge clk);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (board.pending.size() != 0) @(posedge clk);
    repeat (QUIET_CYCLES) @(posedge clk);
  endtask

  initial begin
    board = new();
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // all eight groups at once: press on released only detects, then eight note-ons and eight note-offs
    send_scan(2'd0, 8'hFF, 8'hFF);
    send_scan(2'd0, 8'hFF, 8'hFF);
    send_scan(2'd0, 8'hFF, 8'h00);
    send_scan(2'd0, 8'h00, 8'hFF);
    // short press below the elapsed floor: top velocity
    send_scan(2'd1, 8'h01, 8'h00);
    tick_burst(6);
    send_scan(2'd1, 8'h01, 8'h01);
    send_scan(2'd1, 8'h00, 8'h00);
    // detect then release without press
    send_scan(2'd2, 8'h80, 8'h00);
    send_scan(2'd2, 8'h00, 8'h00);
    send_scan(2'd2, 8'h0F, 8'h00);
    tick_burst(3);
    send_scan(2'd2, 8'h0F, 8'h0F);
    send_scan(2'd2, 8'h0F, 8'h0F);
    send_scan(2'd2, 8'h05, 8'h00);
    send_scan(2'd2, 8'h00, 8'h00);

    for (int ph = 0; ph < 3; ph++) begin
      drain();
      case (ph)
        0: begin
          apb_write(REG_START_NOTE, 32'd0);
          apb_write(REG_WIDE_VEL, 32'd1);
          apb_write(REG_CHANNEL, 32'd15);
          tx_idle_pct <= 14;
          rx_idle_pct <= 46;
          // wide map just above the elapsed floor
          send_scan(2'd3, 8'h80, 8'h00);
          tick_burst(103);
          send_scan(2'd3, 8'h80, 8'h80);
          send_scan(2'd3, 8'h00, 8'h00);
        end
        1: begin
          apb_write(REG_START_NOTE, 32'd127);
          apb_write(REG_WIDE_VEL, 32'd0);
          apb_write(REG_CHANNEL, 32'($urandom_range(15)));
          tx_idle_pct <= 46;
          rx_idle_pct <= 14;
        end
        default: begin
          apb_write(REG_START_NOTE, 32'($urandom_range(127)));
          apb_write(REG_WIDE_VEL, 32'd1);
          apb_write(REG_CHANNEL, 32'd0);
          tx_idle_pct <= 0;
          rx_idle_pct <= 0;
          hold_req <= 1'b1;
          // note bursts behind the held output fill the queue
          for (int c = 0; c < 3; c++) begin
            send_scan(2'(c), 8'h00, 8'h00);
            send_scan(2'(c), 8'hFF, 8'h00);
            send_scan(2'(c), 8'hFF, 8'hFF);
          end
        end
      endcase
      repeat (8) begin
        if ($urandom_range(99) < 35) begin
          tick_burst($urandom_range(1, 4));
        end else begin
          send_beat(make_scan());
        end
      end
    end
    drain();

    if (board.errors == 0) begin
      $display("tb_velocity_key_scanner_top: clean");
    end else begin
      $display("tb_velocity_key_scanner_top: errors");
    end
    $finish;
  end
endmodule
